FILE: rtl/core/i2cbm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbm_pkg: shared types and constants of the I2C bit level master
// Word formats, command codes, sequencer phases and the line action of each
// phase.
// ----------------------------------------------------------------------------
package i2cbm_pkg;

   localparam int HOLD_COUNT_BITS = 16;
   localparam int HALF_STEP_BITS  = 16;

   localparam logic [HALF_STEP_BITS-1:0] HALF_STEP_RESET = HALF_STEP_BITS'(100);

   typedef logic [HOLD_COUNT_BITS-1:0] hold_type;

   localparam logic [32:0] HOLD_MAX = (33'd1 << HOLD_COUNT_BITS) - 33'd1;
   localparam hold_type    HOLD_ONE = HOLD_COUNT_BITS'(1);

   localparam logic [3:0] BITS_PER_BYTE = 4'd8;

   typedef enum logic [2:0] {
      OP_TICK  = 3'd0,
      OP_START = 3'd1,
      OP_STOP  = 3'd2,
      OP_WRITE = 3'd3,
      OP_READ  = 3'd4
   } op_type;

   typedef enum logic [4:0] {
      PH_IDLE        = 5'd0,
      PH_STA_SCL_LO  = 5'd1,
      PH_STA_SDA_HI  = 5'd2,
      PH_STA_SCL_HI  = 5'd3,
      PH_STA_SDA_LO  = 5'd4,
      PH_STA_SCL_END = 5'd5,
      PH_STO_SCL_LO  = 5'd6,
      PH_STO_SDA_LO  = 5'd7,
      PH_STO_SCL_HI  = 5'd8,
      PH_STO_SDA_HI  = 5'd9,
      PH_WR_SCL_LO   = 5'd10,
      PH_WR_SDA_BIT  = 5'd11,
      PH_WR_SCL_HI   = 5'd12,
      PH_WA_SCL_LO   = 5'd13,
      PH_WA_SDA_REL  = 5'd14,
      PH_WA_SCL_HI   = 5'd15,
      PH_WA_SCL_END  = 5'd16,
      PH_RD_SDA_REL  = 5'd17,
      PH_RD_SCL_LO   = 5'd18,
      PH_RD_SCL_HI   = 5'd19,
      PH_RA_SCL_LO   = 5'd20,
      PH_RA_SDA_SET  = 5'd21,
      PH_RA_SCL_HI   = 5'd22,
      PH_RA_SCL_END  = 5'd23,
      PH_RA_SDA_END  = 5'd24
   } phase_type;

   typedef enum logic [2:0] {
      LOP_SCL_LO   = 3'd0,
      LOP_SCL_HI   = 3'd1,
      LOP_SDA_LO   = 3'd2,
      LOP_SDA_HI   = 3'd3,
      LOP_SDA_BIT  = 3'd4,
      LOP_SDA_NAK  = 3'd5,
      LOP_SDA_NNAK = 3'd6
   } line_op_type;

   typedef struct packed {
      logic [2:0] operation;
      logic [7:0] data_byte;
      logic       last_read;
      logic       scl_sense;
      logic       sda_sense;
   } req_type;

   typedef struct packed {
      logic       scl_level;
      logic       sda_level;
      logic       busy_res;
      logic       done_res;
      logic [7:0] read_byte;
      logic       ack_seen;
      logic       refused;
   } rsp_type;

   function automatic line_op_type phase_op(input phase_type ph);
      line_op_type lop;
      unique case (ph)
         PH_STA_SDA_HI,
         PH_STO_SDA_HI,
         PH_WA_SDA_REL,
         PH_RD_SDA_REL: lop = LOP_SDA_HI;
         PH_STA_SCL_HI,
         PH_STO_SCL_HI,
         PH_WR_SCL_HI,
         PH_WA_SCL_HI,
         PH_RD_SCL_HI,
         PH_RA_SCL_HI:  lop = LOP_SCL_HI;
         PH_STA_SDA_LO,
         PH_STO_SDA_LO: lop = LOP_SDA_LO;
         PH_WR_SDA_BIT: lop = LOP_SDA_BIT;
         PH_RA_SDA_SET: lop = LOP_SDA_NAK;
         PH_RA_SDA_END: lop = LOP_SDA_NNAK;
         default:       lop = LOP_SCL_LO;
      endcase
      return lop;
   endfunction

   // clamp the programmed half step to what the hold counter can carry
   function automatic hold_type hold_limit(input logic [HALF_STEP_BITS-1:0] ticks);
      hold_type lim;
      if ({{(33-HALF_STEP_BITS){1'b0}}, ticks} > HOLD_MAX) begin
         lim = HOLD_COUNT_BITS'(HOLD_MAX);
      end else begin
         lim = HOLD_COUNT_BITS'(ticks);
      end
      return lim;
   endfunction

endpackage

FILE: rtl/core/i2cbm_seq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbm_seq: phase sequencer of the I2C bit level master
// Holds the line state, hold counter and shift register; every stepped word
// moves the sequence by one tick and yields that tick's result word.
// ----------------------------------------------------------------------------
module i2cbm_seq (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                step,
   input  i2cbm_pkg::req_type                  req,
   input  logic                                csr_wr_en,
   input  logic [i2cbm_pkg::HALF_STEP_BITS-1:0] csr_wr_data,
   output i2cbm_pkg::rsp_type                  rsp
);
   import i2cbm_pkg::*;

   logic [HALF_STEP_BITS-1:0] half_step_ff;
   phase_type                 phase_ff, phase_in;
   hold_type                  hold_ff, hold_in;
   logic [3:0]                bit_count_ff, bit_count_in;
   logic [7:0]                shift_ff, shift_in;
   logic [7:0]                rx_byte_ff, rx_byte_in;
   logic                      nak_ff, nak_in;
   logic                      ack_ff, ack_in;
   logic                      scl_ff, scl_in;
   logic                      sda_ff, sda_in;

   logic                      enter;
   logic                      done;
   logic                      refused;
   logic                      is_cmd;
   hold_type                  hold_dec;
   logic [3:0]                bit_inc;
   logic [7:0]                shift_next;
   line_op_type               lop;

   assign is_cmd   = (req.operation == OP_START) || (req.operation == OP_STOP) ||
                     (req.operation == OP_WRITE) || (req.operation == OP_READ);
   assign hold_dec = hold_ff - HOLD_ONE;
   assign bit_inc  = bit_count_ff + 4'd1;

   // next state
   always_comb begin
      phase_in     = phase_ff;
      hold_in      = hold_ff;
      bit_count_in = bit_count_ff;
      shift_in     = shift_ff;
      rx_byte_in   = rx_byte_ff;
      nak_in       = nak_ff;
      ack_in       = ack_ff;
      enter        = 1'b0;
      done         = 1'b0;
      refused      = 1'b0;
      shift_next   = {shift_ff[6:0], 1'b0};
      if (phase_ff == PH_IDLE) begin
         if (is_cmd) begin
            bit_count_in = 4'd0;
            enter        = 1'b1;
            unique case (req.operation)
               OP_START: phase_in = PH_STA_SCL_LO;
               OP_STOP:  phase_in = PH_STO_SCL_LO;
               OP_WRITE: begin
                  phase_in = PH_WR_SCL_LO;
                  shift_in = req.data_byte;
               end
               default: begin
                  phase_in = PH_RD_SDA_REL;
                  shift_in = 8'd0;
                  nak_in   = req.last_read;
               end
            endcase
         end
      end else begin
         refused = is_cmd;
         priority if ((hold_ff != '0) && (hold_dec != '0)) begin
            hold_in = hold_dec;
         end else if ((phase_op(phase_ff) == LOP_SCL_HI) && !req.scl_sense) begin
            // SCL stretched by the slave: wait with the hold run out
            hold_in = '0;
         end else begin
            enter = 1'b1;
            unique case (phase_ff)
               PH_WR_SCL_HI: begin
                  shift_in     = shift_next;
                  bit_count_in = bit_inc;
                  phase_in     = (bit_inc < BITS_PER_BYTE) ? PH_WR_SCL_LO : PH_WA_SCL_LO;
               end
               PH_WA_SCL_HI: begin
                  ack_in   = !req.sda_sense;
                  phase_in = PH_WA_SCL_END;
               end
               PH_RD_SCL_HI: begin
                  shift_next   = {shift_ff[6:0], req.sda_sense};
                  shift_in     = shift_next;
                  bit_count_in = bit_inc;
                  if (bit_inc < BITS_PER_BYTE) begin
                     phase_in = PH_RD_SCL_LO;
                  end else begin
                     rx_byte_in = shift_next;
                     phase_in   = PH_RA_SCL_LO;
                  end
               end
               PH_STA_SCL_END,
               PH_STO_SDA_HI,
               PH_WA_SCL_END,
               PH_RA_SDA_END: begin
                  enter    = 1'b0;
                  done     = 1'b1;
                  phase_in = PH_IDLE;
                  hold_in  = '0;
               end
               default: phase_in = phase_type'(phase_ff + 5'd1);
            endcase
         end
      end
      if (enter) begin
         hold_in = hold_limit(half_step_ff);
      end
   end

   // line drive for the phase being entered
   always_comb begin
      scl_in = scl_ff;
      sda_in = sda_ff;
      lop    = phase_op(phase_in);
      if (enter) begin
         unique case (lop)
            LOP_SCL_LO:   scl_in = 1'b0;
            LOP_SCL_HI:   scl_in = 1'b1;
            LOP_SDA_LO:   sda_in = 1'b0;
            LOP_SDA_HI:   sda_in = 1'b1;
            LOP_SDA_BIT:  sda_in = shift_in[7];
            LOP_SDA_NAK:  sda_in = nak_in;
            LOP_SDA_NNAK: sda_in = !nak_in;
            default:      sda_in = sda_ff;
         endcase
      end
   end

   always_comb begin
      rsp.scl_level = scl_in;
      rsp.sda_level = sda_in;
      rsp.busy_res  = (phase_in != PH_IDLE);
      rsp.done_res  = done;
      rsp.read_byte = rx_byte_in;
      rsp.ack_seen  = ack_in;
      rsp.refused   = refused;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         half_step_ff <= HALF_STEP_RESET;
      end else if (csr_wr_en) begin
         half_step_ff <= csr_wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_IDLE;
         hold_ff      <= '0;
         bit_count_ff <= 4'd0;
         shift_ff     <= 8'd0;
         rx_byte_ff   <= 8'd0;
         nak_ff       <= 1'b0;
         ack_ff       <= 1'b0;
         scl_ff       <= 1'b1;
         sda_ff       <= 1'b1;
      end else if (step) begin
         phase_ff     <= phase_in;
         hold_ff      <= hold_in;
         bit_count_ff <= bit_count_in;
         shift_ff     <= shift_in;
         rx_byte_ff   <= rx_byte_in;
         nak_ff       <= nak_in;
         ack_ff       <= ack_in;
         scl_ff       <= scl_in;
         sda_ff       <= sda_in;
      end
   end

endmodule

FILE: rtl/core/i2cbm_skid.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2cbm_skid: result buffer of the I2C bit level master
// Output register plus one skid entry, so a new word is taken while a
// finished one still waits downstream.
// ----------------------------------------------------------------------------
module i2cbm_skid (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   output logic               in_stall,
   input  i2cbm_pkg::rsp_type in_word,
   output logic               out_valid,
   input  logic               out_stall,
   output i2cbm_pkg::rsp_type out_word
);
   import i2cbm_pkg::*;

   logic    out_valid_ff;
   logic    skid_valid_ff;
   rsp_type out_word_ff;
   rsp_type skid_word_ff;
   logic    push;
   logic    pop;

   assign in_stall  = skid_valid_ff;
   assign out_valid = out_valid_ff;
   assign out_word  = out_word_ff;
   assign push      = in_valid && !skid_valid_ff;
   assign pop       = out_valid_ff && !out_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else if (skid_valid_ff) begin
         if (pop) begin
            skid_valid_ff <= 1'b0;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_valid_ff <= 1'b1;
         end else begin
            skid_valid_ff <= 1'b1;
         end
      end else if (pop) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (skid_valid_ff) begin
         if (pop) begin
            out_word_ff <= skid_word_ff;
         end
      end else if (push) begin
         if (!out_valid_ff || pop) begin
            out_word_ff <= in_word;
         end else begin
            skid_word_ff <= in_word;
         end
      end
   end

endmodule

FILE: rtl/core/i2c_bit_level_master.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_bit_level_master: I2C master with phase sequencer and clock stretching
// Start, stop, write byte and read byte on SCL/SDA, paced by tick words.
// ----------------------------------------------------------------------------
//   channel | direction | handshake              | word
//   req     | in        | req_valid / req_stall  | i2cbm_pkg::req_type
//   rsp     | out       | rsp_valid / rsp_stall  | i2cbm_pkg::rsp_type
//   csr     | in        | csr_wr_en              | half step ticks, 16 bit
//
// One word per cycle while req_stall is low; each result is registered in the
// output register, or in the skid entry while a stalled word is held there.
// The sequencer step is a single pass from state registers to the result.
// Reset returns to idle with both lines released and half step 100.
// req_stall rises only once both result entries are held by rsp_stall.
// ----------------------------------------------------------------------------
module i2c_bit_level_master (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  i2cbm_pkg::req_type                  req_word,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output i2cbm_pkg::rsp_type                  rsp_word,
   input  logic                                csr_wr_en,
   input  logic [i2cbm_pkg::HALF_STEP_BITS-1:0] csr_wr_data
);
   import i2cbm_pkg::*;

   logic    step;
   rsp_type step_rsp;

   assign step = req_valid && !req_stall;

   i2cbm_seq u_seq (
      .clock       (clock),
      .reset       (reset),
      .step        (step),
      .req         (req_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .rsp         (step_rsp)
   );

   i2cbm_skid u_skid (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (step),
      .in_stall  (req_stall),
      .in_word   (step_rsp),
      .out_valid (rsp_valid),
      .out_stall (rsp_stall),
      .out_word  (rsp_word)
   );

`ifndef ASSERT_OFF
   a_stall_needs_result : assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("input stalled with no result pending");

   a_done_is_idle : assert property (@(posedge clock) disable iff (reset)
      step && step_rsp.done_res |-> !step_rsp.busy_res)
      else $error("command finished while still busy");

   a_reset_empty : assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("result buffer not empty after reset");

   a_refuse_keeps_busy : assert property (@(posedge clock) disable iff (reset)
      step && step_rsp.refused |-> step_rsp.busy_res || step_rsp.done_res)
      else $error("refused command outside a busy sequence");
`endif

endmodule

FILE: bench/i2c_bit_level_master_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2c_bit_level_master_tb: self-checking bench for the I2C bit level master
// A table of directed words covers reset, refused and spare commands, zero
// and unit half steps, SCL stretching and both read endings. Random command
// sequences with random line levels follow at short half steps, and a single
// start at the largest half step closes the run. Every result word is checked
// field by field against a cycle-free model of the phase sequencer.
// ----------------------------------------------------------------------------
module i2c_bit_level_master_tb;
   import i2cbm_pkg::*;

   localparam int RESET_CYCLES       = 7;
   localparam int WATCHDOG_LIMIT     = 1000;
   localparam int HOLD_OFF_CYCLES    = 60;
   localparam int RAND_ITEMS_PER_SET = 40;
   localparam int END_TICKS          = 30;
   localparam int END_SETTLE_CYCLES  = 8;

   // operation codes the block treats as plain ticks
   localparam logic [2:0] OP_SPARE_LO  = 3'd5;
   localparam logic [2:0] OP_SPARE_MID = 3'd6;
   localparam logic [2:0] OP_SPARE_HI  = 3'd7;

   typedef enum logic [1:0] {
      ROW_ITEM,
      ROW_CFG,
      ROW_RUN
   } row_kind_type;

   typedef struct packed {
      row_kind_type kind;
      logic [15:0]  cfg_value;
      logic [15:0]  reps;
      req_type      word;
      logic         typed;
      rsp_type      exp;
   } dir_row_type;

   localparam int DIR_ROWS = 24;

   dir_row_type dir_tab [0:DIR_ROWS-1] = '{
      '{ROW_ITEM, 16'd0, 16'd1, '{OP_TICK, 8'h00, 1'b0, 1'b1, 1'b1}, 1'b1,
        '{1'b1, 1'b1, 1'b0, 1'b0, 8'h00, 1'b0, 1'b0}},
      '{ROW_ITEM, 16'd0, 16'd1, '{OP_START, 8'hFF, 1'b1, 1'b1, 1'b1}, 1'b1,
        '{1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0}},
      '{ROW_ITEM, 16'd0, 16'd1, '{OP_WRITE, 8'h00, 1'b0, 1'b1, 1'b0}, 1'b1,
        '{1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b1}},
      '{ROW_ITEM, 16'd0, 16'd1, '{OP_SPARE_HI, 8'hFF, 1'b1, 1'b1, 1'b1}, 1'b1,
        '{1'b0, 1'b1, 1'b1, 1'b0, 8'h00, 1'b0, 1'b0}},
      '{ROW_ITEM, 16'd0, 16'd3, '{OP_TICK, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
      '{ROW_CFG,  16'd0, 16'd0, '0, 1'b0, '0},
      '{ROW_RUN,  16'd0, 16'd0, '0, 1'b0, '0},
      '{ROW_ITEM, 16'd0, 16'd1, '{OP_WRITE, 8'hA5, 1'b0, 1'b1, 1'b1}, 1'b0, '0},
      '{ROW_ITEM, 16'd0, 16'd1, '{OP_STOP, 8'h00, 1'b0, 1'b1, 1'b1}, 1'b0, '0},
      '{ROW_ITEM, 16'd0, 16'd8, '{OP_TICK, 8'h00, 1'b0, 1'b0, 1'b0}, 1'b0, '0},
      '{ROW_RUN,  16'd0, 16'd0, '0, 1'b0, '0},
      '{ROW_CFG,  16'd1, 16'd0, '0, 1'b0, '0},
      '{ROW_ITEM, 16'd0, 16'd1, '{OP_READ, 8'h00, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
      '{ROW_RUN,  16'd0, 16'd0, '0, 1'b0, '0},
      '{ROW_ITEM, 16'd0, 16'd1, '{OP_READ, 8'hFF, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
      '{ROW_RUN,  16'd0, 16'd0, '0, 1'b0, '0},
      '{ROW_ITEM, 16'd0, 16'd1, '{OP_WRITE, 8'hFF, 1'b1, 1'b1, 1'b0}, 1'b0, '0},
      '{ROW_RUN,  16'd0, 16'd0, '0, 1'b0, '0},
      '{ROW_ITEM, 16'd0, 16'd1, '{OP_STOP, 8'hFF, 1'b1, 1'b1, 1'b1}, 1'b0, '0},
      '{ROW_RUN,  16'd0, 16'd0, '0, 1'b0, '0},
      '{ROW_ITEM, 16'd0, 16'd1, '{OP_SPARE_LO, 8'h5A, 1'b1, 1'b0, 1'b1}, 1'b0, '0},
      '{ROW_ITEM, 16'd0, 16'd1, '{OP_SPARE_MID, 8'hC3, 1'b0, 1'b1, 1'b0}, 1'b0, '0},
      '{ROW_ITEM, 16'd0, 16'd1, '{OP_START, 8'h00, 1'b0, 1'b1, 1'b1}, 1'b0, '0},
      '{ROW_RUN,  16'd0, 16'd0, '0, 1'b0, '0}
   };

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic                      req_stall;
   req_type                   req_word    = '0;
   logic                      rsp_valid;
   logic                      rsp_stall   = 1'b0;
   rsp_type                   rsp_word;
   logic                      csr_wr_en   = 1'b0;
   logic [HALF_STEP_BITS-1:0] csr_wr_data = '0;

   // sequencer model state
   logic [HALF_STEP_BITS-1:0] mdl_half_step = HALF_STEP_RESET;
   phase_type                 mdl_phase     = PH_IDLE;
   logic [3:0]                mdl_bits      = '0;
   logic [7:0]                mdl_shift     = '0;
   hold_type                  mdl_hold      = '0;
   logic                      mdl_nak       = 1'b0;
   logic                      mdl_scl       = 1'b1;
   logic                      mdl_sda       = 1'b1;
   logic                      mdl_ack       = 1'b0;
   logic [7:0]                mdl_rx_byte   = '0;

   rsp_type expected_rsp_q [$];

   int  fail_count    = 0;
   int  checked_count = 0;
   int  cmd_count     = 0;
   int  refused_count = 0;
   int  quiet_cycles  = 0;
   bit  gaps_on       = 1'b1;
   bit  hold_off_asked = 1'b0;
   bit  hold_off_done  = 1'b0;

   i2c_bit_level_master u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_word    (req_word),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_word    (rsp_word),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #5 clock = ~clock;

   function automatic logic releases_scl(input phase_type p);
      return (p == PH_STA_SCL_HI) || (p == PH_STO_SCL_HI) || (p == PH_WR_SCL_HI) ||
             (p == PH_WA_SCL_HI) || (p == PH_RD_SCL_HI) || (p == PH_RA_SCL_HI);
   endfunction

   function automatic void load_phase(input phase_type p);
      longint unsigned cap;
      cap = (64'd1 << HOLD_COUNT_BITS) - 64'd1;
      mdl_phase = p;
      case (p)
         PH_STA_SDA_HI, PH_STO_SDA_HI, PH_WA_SDA_REL, PH_RD_SDA_REL: mdl_sda = 1'b1;
         PH_STA_SDA_LO, PH_STO_SDA_LO: mdl_sda = 1'b0;
         PH_WR_SDA_BIT: mdl_sda = mdl_shift[7];
         PH_RA_SDA_SET: mdl_sda = mdl_nak;
         PH_RA_SDA_END: mdl_sda = ~mdl_nak;
         default: mdl_scl = releases_scl(p);
      endcase
      if (longint'(mdl_half_step) > cap) begin
         mdl_hold = hold_type'(cap);
      end else begin
         mdl_hold = hold_type'(mdl_half_step);
      end
   endfunction

   // one tick of a running command; returns 1 when the command completes
   function automatic logic step_sequence(input logic scl_in, input logic sda_in);
      phase_type nxt;
      if (mdl_hold != '0) begin
         mdl_hold = mdl_hold - 1'b1;
         if (mdl_hold != '0) return 1'b0;
      end
      // stretch: wait for the slave to let SCL go high
      if (releases_scl(mdl_phase) && !scl_in) return 1'b0;
      case (mdl_phase)
         PH_WR_SCL_HI: begin
            mdl_shift = {mdl_shift[6:0], 1'b0};
            mdl_bits  = mdl_bits + 1'b1;
            nxt = (mdl_bits < 4'd8) ? PH_WR_SCL_LO : PH_WA_SCL_LO;
         end
         PH_WA_SCL_HI: begin
            mdl_ack = ~sda_in;
            nxt = PH_WA_SCL_END;
         end
         PH_RD_SCL_HI: begin
            mdl_shift = {mdl_shift[6:0], sda_in};
            mdl_bits  = mdl_bits + 1'b1;
            if (mdl_bits < 4'd8) begin
               nxt = PH_RD_SCL_LO;
            end else begin
               mdl_rx_byte = mdl_shift;
               nxt = PH_RA_SCL_LO;
            end
         end
         PH_STA_SCL_END, PH_STO_SDA_HI, PH_WA_SCL_END, PH_RA_SDA_END: nxt = PH_IDLE;
         default: nxt = phase_type'(mdl_phase + 5'd1);
      endcase
      if (nxt == PH_IDLE) begin
         mdl_phase = PH_IDLE;
         mdl_hold  = '0;
         return 1'b1;
      end
      load_phase(nxt);
      return 1'b0;
   endfunction

   function automatic rsp_type i2c_predict(input req_type w);
      rsp_type r;
      logic    is_cmd;
      r = '0;
      is_cmd = (w.operation >= OP_START) && (w.operation <= OP_READ);
      if (mdl_phase == PH_IDLE) begin
         if (is_cmd) begin
            cmd_count++;
            mdl_bits = '0;
            case (w.operation)
               OP_START: load_phase(PH_STA_SCL_LO);
               OP_STOP:  load_phase(PH_STO_SCL_LO);
               OP_WRITE: begin
                  mdl_shift = w.data_byte;
                  load_phase(PH_WR_SCL_LO);
               end
               default: begin
                  mdl_shift = '0;
                  mdl_nak   = w.last_read;
                  load_phase(PH_RD_SDA_REL);
               end
            endcase
         end
      end else begin
         r.refused  = is_cmd;
         r.done_res = step_sequence(w.scl_sense, w.sda_sense);
         if (is_cmd) refused_count++;
      end
      r.scl_level = mdl_scl;
      r.sda_level = mdl_sda;
      r.busy_res  = (mdl_phase != PH_IDLE);
      r.read_byte = mdl_rx_byte;
      r.ack_seen  = mdl_ack;
      return r;
   endfunction

   function automatic req_type rand_word(input logic [2:0] op);
      req_type w;
      w.operation = op;
      w.data_byte = 8'($urandom_range(0, 255));
      w.last_read = 1'($urandom_range(0, 1));
      w.scl_sense = ($urandom_range(0, 7) != 0);
      w.sda_sense = 1'($urandom_range(0, 1));
      return w;
   endfunction

   // offer one word, hold it until taken, then log what it should produce
   task automatic send_word(input req_type w, input logic typed, input rsp_type typed_exp);
      rsp_type e;
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
      end
      req_word  <= w;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      e = i2c_predict(w);
      expected_rsp_q.push_back(typed ? typed_exp : e);
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_rsp_q.size() != 0) @(posedge clock);
   endtask

   // tick a running command to its end; commands sent here are refused
   task automatic settle_sequence();
      logic [2:0] op;
      while (mdl_phase != PH_IDLE) begin
         op = ($urandom_range(0, 3) != 0) ? OP_TICK : 3'($urandom_range(0, 7));
         send_word(rand_word(op), 1'b0, '0);
      end
   endtask

   // a new half step takes effect at the next line change
   task automatic write_half_step(input logic [HALF_STEP_BITS-1:0] value);
      drain_results();
      csr_wr_data <= value;
      csr_wr_en   <= 1'b1;
      @(posedge clock);
      csr_wr_en     <= 1'b0;
      mdl_half_step  = value;
   endtask

   // result side: compare each taken word with the oldest expectation
   always @(posedge clock) begin
      rsp_type e;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_rsp_q.size() == 0) begin
            $error("result word with nothing expected: %h", rsp_word);
            fail_count++;
         end else begin
            e = expected_rsp_q.pop_front();
            checked_count++;
            if (rsp_word.scl_level !== e.scl_level) begin
               $error("scl_level expected %0d got %0d", e.scl_level, rsp_word.scl_level);
               fail_count++;
            end
            if (rsp_word.sda_level !== e.sda_level) begin
               $error("sda_level expected %0d got %0d", e.sda_level, rsp_word.sda_level);
               fail_count++;
            end
            if (rsp_word.busy_res !== e.busy_res) begin
               $error("busy_res expected %0d got %0d", e.busy_res, rsp_word.busy_res);
               fail_count++;
            end
            if (rsp_word.done_res !== e.done_res) begin
               $error("done_res expected %0d got %0d", e.done_res, rsp_word.done_res);
               fail_count++;
            end
            if (rsp_word.read_byte !== e.read_byte) begin
               $error("read_byte expected %h got %h", e.read_byte, rsp_word.read_byte);
               fail_count++;
            end
            if (rsp_word.ack_seen !== e.ack_seen) begin
               $error("ack_seen expected %0d got %0d", e.ack_seen, rsp_word.ack_seen);
               fail_count++;
            end
            if (rsp_word.refused !== e.refused) begin
               $error("refused expected %0d got %0d", e.refused, rsp_word.refused);
               fail_count++;
            end
         end
      end
   end

   // result side backpressure
   initial begin
      forever begin
         if (hold_off_asked && !hold_off_done) begin
            hold_off_done = 1'b1;
            rsp_stall <= 1'b1;
            repeat (HOLD_OFF_CYCLES) @(posedge clock);
         end else if (gaps_on && $urandom_range(0, 2) == 0) begin
            rsp_stall <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end else begin
            rsp_stall <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clock);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_wr_en) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      logic [HALF_STEP_BITS-1:0] rand_steps [0:3];
      logic [2:0]                op;
      logic [2:0]                last_cmd;
      logic                      last_nak;
      req_type                   w;
      int                        r;

      rand_steps = '{16'd1, 16'd2, 16'd3, 16'd1};
      last_cmd   = OP_STOP;
      last_nak   = 1'b0;

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < DIR_ROWS; i++) begin
         case (dir_tab[i].kind)
            ROW_ITEM: begin
               repeat (dir_tab[i].reps) send_word(dir_tab[i].word, dir_tab[i].typed,
                                                  dir_tab[i].exp);
            end
            ROW_CFG: write_half_step(dir_tab[i].cfg_value);
            default: settle_sequence();
         endcase
      end

      for (int s = 0; s < 4; s++) begin
         write_half_step(rand_steps[s]);
         for (int i = 0; i < RAND_ITEMS_PER_SET; i++) begin
            if (i % 40 == 0) gaps_on = ($urandom_range(0, 3) != 0);
            if (s == 1 && i == 20) hold_off_asked = 1'b1;
            if (s == 2 && i == 30) drain_results();
            r = $urandom_range(0, 19);
            if (mdl_phase == PH_IDLE) begin
               if (r < 15) begin
                  // mostly well-formed transfers: start, address, data, stop
                  case (last_cmd)
                     OP_START: op = OP_WRITE;
                     OP_WRITE: op = 3'($urandom_range(OP_STOP, OP_READ));
                     OP_READ:  op = last_nak ? 3'($urandom_range(OP_START, OP_STOP))
                                             : OP_READ;
                     default:  op = OP_START;
                  endcase
               end else if (r < 17) begin
                  op = 3'($urandom_range(OP_START, OP_READ));
               end else if (r < 18) begin
                  op = OP_TICK;
               end else begin
                  op = 3'($urandom_range(OP_SPARE_LO, OP_SPARE_HI));
               end
            end else begin
               if (r < 17) op = OP_TICK;
               else op = 3'($urandom_range(0, 7));
            end
            w = rand_word(op);
            if (mdl_phase == PH_IDLE && op >= OP_START && op <= OP_READ) begin
               last_cmd = op;
               last_nak = w.last_read;
            end
            send_word(w, 1'b0, '0);
         end
      end

      // last part: no gaps, largest half step on the opening of a start
      gaps_on = 1'b0;
      settle_sequence();
      write_half_step(16'hFFFF);
      send_word(rand_word(OP_START), 1'b0, '0);
      repeat (END_TICKS) send_word(rand_word(OP_TICK), 1'b0, '0);
      drain_results();
      repeat (END_SETTLE_CYCLES) @(posedge clock);

      $display("tb: %0d result words checked over %0d commands, %0d refused,",
               checked_count, cmd_count, refused_count);
      $display("tb: half steps 100, 0, 1, 2, 3 and 65535 with SCL stretching and stalls");
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
